// ----- rtl/lts_pkg.sv -----
// Shared types, codes and reset values for the link transaction sequencer.
// Used by every module of the block and by its port checker; depends on nothing.
package lts_pkg;

	// Field and register widths.
	localparam int unsigned TimeW  = 16;
	localparam int unsigned RetryW = 4;
	localparam int unsigned PhaseW = 3;
	localparam int unsigned CmdW   = 2;
	localparam int unsigned ReplyW = 2;
	localparam int unsigned IdxW   = 3;

	// Configuration register indexes.
	localparam logic [IdxW-1:0] REG_CONNECT_TIMEOUT = 3'd0;
	localparam logic [IdxW-1:0] REG_REPLY_TIMEOUT   = 3'd1;
	localparam logic [IdxW-1:0] REG_CLOSE_HOLD      = 3'd2;
	localparam logic [IdxW-1:0] REG_RETRY_LIMIT     = 3'd3;
	localparam logic [IdxW-1:0] REG_HOST_PRESENT    = 3'd4;

	// Register reset values.
	localparam logic [TimeW-1:0]  RST_CONNECT_TIMEOUT = 16'd10000;
	localparam logic [TimeW-1:0]  RST_REPLY_TIMEOUT   = 16'd20000;
	localparam logic [TimeW-1:0]  RST_CLOSE_HOLD      = 16'd500;
	localparam logic [RetryW-1:0] RST_RETRY_LIMIT     = 4'd3;
	localparam logic              RST_HOST_PRESENT    = 1'b1;

	// Command codes on the result word.
	localparam logic [CmdW-1:0] CMD_NONE    = 2'd0;
	localparam logic [CmdW-1:0] CMD_CONNECT = 2'd1;
	localparam logic [CmdW-1:0] CMD_SEND    = 2'd2;
	localparam logic [CmdW-1:0] CMD_CLOSE   = 2'd3;

	// Reply codes.
	localparam logic [ReplyW-1:0] REPLY_GOOD   = 2'd1;
	localparam logic [ReplyW-1:0] REPLY_REJECT = 2'd2;

	// Phase codes as they appear on the result word.
	localparam logic [PhaseW-1:0] PHASE_IDLE      = 3'd0;
	localparam logic [PhaseW-1:0] PHASE_CHECK     = 3'd1;
	localparam logic [PhaseW-1:0] PHASE_CONNECT   = 3'd2;
	localparam logic [PhaseW-1:0] PHASE_WAITCONN  = 3'd3;
	localparam logic [PhaseW-1:0] PHASE_SEND      = 3'd4;
	localparam logic [PhaseW-1:0] PHASE_WAITREPLY = 3'd5;
	localparam logic [PhaseW-1:0] PHASE_CLOSE     = 3'd6;
	localparam logic [PhaseW-1:0] PHASE_HOLD      = 3'd7;

	localparam logic [TimeW-1:0]  TIME_MAX  = '1;
	localparam logic [RetryW-1:0] RETRY_MAX = '1;

	// Internal one-hot phase state.
	typedef enum logic [7:0] {
		ST_IDLE      = 8'b0000_0001,
		ST_CHECK     = 8'b0000_0010,
		ST_CONNECT   = 8'b0000_0100,
		ST_WAITCONN  = 8'b0000_1000,
		ST_SEND      = 8'b0001_0000,
		ST_WAITREPLY = 8'b0010_0000,
		ST_CLOSE     = 8'b0100_0000,
		ST_HOLD      = 8'b1000_0000
	} phase_t;

	// Configuration register set.
	typedef struct packed {
		logic [TimeW-1:0]  connect_timeout;
		logic [TimeW-1:0]  reply_timeout;
		logic [TimeW-1:0]  close_hold;
		logic [RetryW-1:0] retry_limit;
		logic              host_present;
	} cfg_t;

	// One input word.
	typedef struct packed {
		logic              request;
		logic              link_up;
		logic [ReplyW-1:0] reply_status;
		logic              tick;
	} item_t;

	// One result word.
	typedef struct packed {
		logic [CmdW-1:0]   command;
		logic              busy_res;
		logic [PhaseW-1:0] phase;
	} result_t;

	// Encodes the one-hot phase into its three-bit result code.
	function automatic logic [PhaseW-1:0] phase_code(input phase_t st);
		logic [PhaseW-1:0] code;
		case (st)
			ST_IDLE:      code = PHASE_IDLE;
			ST_CHECK:     code = PHASE_CHECK;
			ST_CONNECT:   code = PHASE_CONNECT;
			ST_WAITCONN:  code = PHASE_WAITCONN;
			ST_SEND:      code = PHASE_SEND;
			ST_WAITREPLY: code = PHASE_WAITREPLY;
			ST_CLOSE:     code = PHASE_CLOSE;
			ST_HOLD:      code = PHASE_HOLD;
			default:      code = PHASE_IDLE;
		endcase
		return code;
	endfunction

endpackage

// ----- rtl/lts_cfg.sv -----
// Configuration register file of the link transaction sequencer.
// Depends on lts_pkg for the register indexes, reset values and cfg_t.
module lts_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [lts_pkg::IdxW-1:0]  cfg_index,
	input  logic [lts_pkg::TimeW-1:0] cfg_data,
	output lts_pkg::cfg_t             cfg
);
	import lts_pkg::*;

	cfg_t cfg_q;

	// Writes are always accepted; cfg_ready is tied high.
	assign cfg_ready = 1'b1;
	assign cfg     = cfg_q;

	// Register writes; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.connect_timeout <= RST_CONNECT_TIMEOUT;
			cfg_q.reply_timeout   <= RST_REPLY_TIMEOUT;
			cfg_q.close_hold      <= RST_CLOSE_HOLD;
			cfg_q.retry_limit     <= RST_RETRY_LIMIT;
			cfg_q.host_present    <= RST_HOST_PRESENT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CONNECT_TIMEOUT: cfg_q.connect_timeout <= cfg_data;
				REG_REPLY_TIMEOUT:   cfg_q.reply_timeout   <= cfg_data;
				REG_CLOSE_HOLD:      cfg_q.close_hold      <= cfg_data;
				REG_RETRY_LIMIT:     cfg_q.retry_limit     <= cfg_data[RetryW-1:0];
				REG_HOST_PRESENT:    cfg_q.host_present    <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/lts_fsm.sv -----
// Phase sequencer: phase, busy, retry and elapsed-time state and the one-step update.
// Depends on lts_pkg for phase_t, cfg_t, item_t, result_t and the codes.
module lts_fsm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  lts_pkg::item_t   item,
	input  lts_pkg::cfg_t    cfg,
	output lts_pkg::result_t result
);
	import lts_pkg::*;

	phase_t            phase_q, phase_d;
	logic              busy_q, busy_d;
	logic [RetryW-1:0] retry_q, retry_d;
	logic [TimeW-1:0]  elapsed_q, elapsed_d;

	logic [TimeW-1:0]  elapsed_adv;
	logic [RetryW-1:0] retry_inc;
	logic              spent;
	logic              got_reply;
	logic [CmdW-1:0]   command;

	// Time advance, saturating retry count and reply decode.
	assign elapsed_adv = (item.tick && (elapsed_q != TIME_MAX)) ?
		elapsed_q + TimeW'(1) : elapsed_q;
	assign retry_inc = (retry_q != RETRY_MAX) ? retry_q + RetryW'(1) : retry_q;
	assign spent     = (retry_inc >= cfg.retry_limit);
	assign got_reply = (item.reply_status == REPLY_GOOD) ||
		(item.reply_status == REPLY_REJECT);

	// Next state for one polled word.
	always_comb begin
		phase_d   = phase_q;
		busy_d    = busy_q;
		retry_d   = retry_q;
		elapsed_d = elapsed_q;
		command   = CMD_NONE;
		case (phase_q)
			ST_IDLE: begin
				if (item.request) begin
					retry_d = '0;
					busy_d  = 1'b1;
					phase_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				phase_d = item.link_up ? ST_SEND : ST_CONNECT;
			end
			ST_CONNECT: begin
				elapsed_d = '0;
				if (cfg.host_present) begin
					command = CMD_CONNECT;
					phase_d = ST_WAITCONN;
				end else begin
					phase_d = ST_IDLE;
					busy_d  = 1'b0;
				end
			end
			ST_WAITCONN: begin
				if (item.link_up) begin
					phase_d = ST_SEND;
				end else begin
					elapsed_d = elapsed_adv;
					if (elapsed_adv > cfg.connect_timeout) begin
						retry_d = retry_inc;
						if (spent) begin
							phase_d = ST_IDLE;
							busy_d  = 1'b0;
						end else begin
							phase_d = ST_CONNECT;
						end
					end
				end
			end
			ST_SEND: begin
				elapsed_d = '0;
				if (cfg.host_present) begin
					command = CMD_SEND;
					phase_d = ST_WAITREPLY;
				end else begin
					phase_d = ST_IDLE;
					busy_d  = 1'b0;
				end
			end
			ST_WAITREPLY: begin
				if (got_reply) begin
					phase_d = ST_CLOSE;
				end else begin
					elapsed_d = elapsed_adv;
					if (elapsed_adv > cfg.reply_timeout) begin
						retry_d = retry_inc;
						phase_d = spent ? ST_CLOSE : ST_SEND;
					end
				end
			end
			ST_CLOSE: begin
				elapsed_d = '0;
				if (cfg.host_present) begin
					command = CMD_CLOSE;
					phase_d = ST_HOLD;
				end else begin
					phase_d = ST_IDLE;
					busy_d  = 1'b0;
				end
			end
			ST_HOLD: begin
				elapsed_d = elapsed_adv;
				if (elapsed_adv > cfg.close_hold) begin
					phase_d = ST_IDLE;
					busy_d  = 1'b0;
				end
			end
			default: begin
				phase_d = ST_IDLE;
				busy_d  = 1'b0;
			end
		endcase
	end

	// The result reports the state after this step.
	assign result.command  = command;
	assign result.busy_res = busy_d;
	assign result.phase    = phase_code(phase_d);

	// State moves only when a word is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ST_IDLE;
			busy_q    <= 1'b0;
			retry_q   <= '0;
			elapsed_q <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			busy_q    <= busy_d;
			retry_q   <= retry_d;
			elapsed_q <= elapsed_d;
		end
	end

endmodule

// ----- rtl/link_transaction_sequencer.sv -----
// Top level of the link transaction sequencer: input register, sequencer, result register.
// Depends on lts_pkg, lts_cfg and lts_fsm.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  in       | in_valid / in_ready    | request, link_up, reply_status, tick
//  out      | out_valid / out_ready  | command, busy_res, phase
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One word is taken per cycle while in_ready is high; the result register offers its result.
// The input register feeds the sequencer update, whose result lands in the result register.
// Reset clears the sequencer to idle and loads the register defaults.
// A stalled result holds; one further word waits in the input register, then in_ready drops.
// Configuration writes complete in the cycle they are offered.
module link_transaction_sequencer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       request,
	input  logic                       link_up,
	input  logic [lts_pkg::ReplyW-1:0] reply_status,
	input  logic                       tick,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lts_pkg::CmdW-1:0]   command,
	output logic                       busy_res,
	output logic [lts_pkg::PhaseW-1:0] phase,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [lts_pkg::IdxW-1:0]   cfg_index,
	input  logic [lts_pkg::TimeW-1:0]  cfg_data
);
	import lts_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    step;
	result_t result;
	result_t result_q;
	logic    out_valid_q;

	// Handshake: the stage advances when the result register is free or being drained.
	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.request      <= request;
			item_s1.link_up      <= link_up;
			item_s1.reply_status <= reply_status;
			item_s1.tick         <= tick;
		end
	end

	lts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lts_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign command   = result_q.command;
	assign busy_res  = result_q.busy_res;
	assign phase     = result_q.phase;

endmodule

// ----- rtl/lts_checker.sv -----
// Port-level checker for the link transaction sequencer, with its bind.
// Depends on lts_pkg for the command and phase codes.
module lts_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [lts_pkg::CmdW-1:0]   command,
	input logic                       busy_res,
	input logic [lts_pkg::PhaseW-1:0] phase
);
	import lts_pkg::*;

	// A stalled result word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(command) &&
			$stable(busy_res) && $stable(phase))
		else $error("result word changed while stalled");

	// Busy is reported exactly when the phase is not idle.
	a_busy_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (busy_res == (phase != PHASE_IDLE)))
		else $error("busy flag disagrees with phase");

	// Each issued command leads into its matching wait phase.
	a_cmd_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command != CMD_NONE |->
			(command == CMD_CONNECT && phase == PHASE_WAITCONN) ||
			(command == CMD_SEND && phase == PHASE_WAITREPLY) ||
			(command == CMD_CLOSE && phase == PHASE_HOLD))
		else $error("command issued with wrong phase");

	// A word after a hold result is either still in hold or back in idle.
	a_hold_exit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && phase == PHASE_HOLD ##1 out_valid |->
			phase == PHASE_HOLD || phase == PHASE_IDLE)
		else $error("hold phase left to an unexpected phase");

endmodule

bind link_transaction_sequencer lts_checker u_lts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.command   (command),
	.busy_res  (busy_res),
	.phase     (phase)
);

// ----- sim/tb_link_transaction_sequencer.sv -----
// Self-checking testbench for the link transaction sequencer: directed polls, a full-scale
// hold, then random transactions under several idling modes.
// Depends on lts_pkg and link_transaction_sequencer from the rtl folder.
module tb_link_transaction_sequencer;
	import lts_pkg::*;

	// Reply codes the package leaves unnamed, and an index that maps to no register.
	localparam logic [ReplyW-1:0] REPLY_NONE   = 2'd0;
	localparam logic [ReplyW-1:0] REPLY_UNUSED = 2'd3;
	localparam logic [IdxW-1:0]   REG_UNMAPPED = 3'd7;

	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD   = 80;
	localparam int PHASE_POLLS = 180;

	// Tracks the sequencer state word by word and checks every result against it.
	class poll_tracker;
		cfg_t               regs;
		logic [PhaseW-1:0]  phase_now;
		logic               busy;
		logic [RetryW-1:0]  retries;
		logic [TimeW-1:0]   elapsed;
		result_t            awaited[$];
		int                 failures;

		function new();
			regs.connect_timeout = RST_CONNECT_TIMEOUT;
			regs.reply_timeout   = RST_REPLY_TIMEOUT;
			regs.close_hold      = RST_CLOSE_HOLD;
			regs.retry_limit     = RST_RETRY_LIMIT;
			regs.host_present    = RST_HOST_PRESENT;
			phase_now = PHASE_IDLE;
			busy      = 1'b0;
			retries   = '0;
			elapsed   = '0;
			failures  = 0;
		endfunction

		function void load_reg(input logic [IdxW-1:0] idx, input logic [TimeW-1:0] data);
			case (idx)
				REG_CONNECT_TIMEOUT: regs.connect_timeout = data;
				REG_REPLY_TIMEOUT:   regs.reply_timeout = data;
				REG_CLOSE_HOLD:      regs.close_hold = data;
				REG_RETRY_LIMIT:     regs.retry_limit = data[RetryW-1:0];
				REG_HOST_PRESENT:    regs.host_present = data[0];
				default: ;
			endcase
		endfunction

		function void drop_to_idle();
			phase_now = PHASE_IDLE;
			busy = 1'b0;
		endfunction

		// The elapsed counter saturates rather than wrapping.
		function void count_tick(input logic tk);
			if (tk && elapsed != TIME_MAX)
				elapsed++;
		endfunction

		// One shared retry count; true once the limit is reached.
		function bit retries_exhausted();
			if (retries != RETRY_MAX)
				retries++;
			return retries >= regs.retry_limit;
		endfunction

		// Advances the sequencer by one accepted word and queues the result it yields.
		function void note_poll(input item_t w);
			logic [CmdW-1:0] cmd;
			result_t want;
			cmd = CMD_NONE;
			case (phase_now)
				PHASE_IDLE: begin
					if (w.request) begin
						retries = '0;
						busy = 1'b1;
						phase_now = PHASE_CHECK;
					end
				end
				PHASE_CHECK: begin
					phase_now = w.link_up ? PHASE_SEND : PHASE_CONNECT;
				end
				PHASE_CONNECT: begin
					elapsed = '0;
					if (regs.host_present) begin
						cmd = CMD_CONNECT;
						phase_now = PHASE_WAITCONN;
					end else
						drop_to_idle();
				end
				PHASE_WAITCONN: begin
					// A link coming up beats a timeout in the same poll.
					if (w.link_up)
						phase_now = PHASE_SEND;
					else begin
						count_tick(w.tick);
						if (elapsed > regs.connect_timeout) begin
							if (retries_exhausted())
								drop_to_idle();
							else
								phase_now = PHASE_CONNECT;
						end
					end
				end
				PHASE_SEND: begin
					elapsed = '0;
					if (regs.host_present) begin
						cmd = CMD_SEND;
						phase_now = PHASE_WAITREPLY;
					end else
						drop_to_idle();
				end
				PHASE_WAITREPLY: begin
					// A good or reject reply beats a timeout; the unused code means no reply.
					if (w.reply_status == REPLY_GOOD || w.reply_status == REPLY_REJECT)
						phase_now = PHASE_CLOSE;
					else begin
						count_tick(w.tick);
						if (elapsed > regs.reply_timeout)
							phase_now = retries_exhausted() ? PHASE_CLOSE : PHASE_SEND;
					end
				end
				PHASE_CLOSE: begin
					elapsed = '0;
					if (regs.host_present) begin
						cmd = CMD_CLOSE;
						phase_now = PHASE_HOLD;
					end else
						drop_to_idle();
				end
				default: begin
					count_tick(w.tick);
					if (elapsed > regs.close_hold)
						drop_to_idle();
				end
			endcase
			want.command  = cmd;
			want.busy_res = busy;
			want.phase    = phase_now;
			awaited.push_back(want);
		endfunction

		function void check_poll(input result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				$error("result with nothing outstanding: command %0d busy_res %0d phase %0d",
					got.command, got.busy_res, got.phase);
				failures++;
				return;
			end
			want = awaited.pop_front();
			if (got.command !== want.command) begin
				$error("command: expected %0d, got %0d", want.command, got.command);
				failures++;
			end
			if (got.busy_res !== want.busy_res) begin
				$error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
				failures++;
			end
			if (got.phase !== want.phase) begin
				$error("phase: expected %0d, got %0d", want.phase, got.phase);
				failures++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                request;
	logic                link_up;
	logic [ReplyW-1:0]   reply_status;
	logic                tick;
	logic                out_valid;
	logic                out_ready;
	logic [CmdW-1:0]     command;
	logic                busy_res;
	logic [PhaseW-1:0]   phase;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [IdxW-1:0]     cfg_index;
	logic [TimeW-1:0]    cfg_data;

	poll_tracker sb = new();

	int gap_pct;
	int stall_pct;
	int hold_requests;
	int holds_seen;
	int hold_left;
	int idle_cycles;
	int link_pct;
	int reply_pct;
	int tick_pct;
	int pass_no;
	int n;
	logic [ReplyW-1:0] reply_pick;

	link_transaction_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.request(request),
		.link_up(link_up),
		.reply_status(reply_status),
		.tick(tick),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.command(command),
		.busy_res(busy_res),
		.phase(phase),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
	always @(negedge clk) begin
		if (hold_requests != holds_seen) begin
			holds_seen = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else
			out_ready = ($urandom_range(99) >= stall_pct);
	end

	// Every result word is checked at the edge that takes it.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_poll({command, busy_res, phase});
	end

	// Watchdog: ends the run if no channel moves a word for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Offers one input word, holding it until taken; returns at the next falling edge.
	task automatic send_poll(input logic req, input logic link, input logic [ReplyW-1:0] reply,
			input logic tk);
		item_t w;
		w = {req, link, reply, tk};
		while ($urandom_range(99) < gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		request = w.request;
		link_up = w.link_up;
		reply_status = w.reply_status;
		tick = w.tick;
		do @(posedge clk); while (!in_ready);
		sb.note_poll(w);
		@(negedge clk);
	endtask

	// Stops offering words until every outstanding result has been taken.
	task automatic wait_all_results();
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [IdxW-1:0] idx, input logic [TimeW-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.load_reg(idx, data);
		@(negedge clk);
	endtask

	// Drains the block, then rewrites every register; narrow registers get junk upper bits.
	task automatic apply_settings(input int ct, input int rt, input int ch, input int rl,
			input logic host, input bit unmapped);
		logic [TimeW-1:0] junk;
		junk = TimeW'($urandom);
		wait_all_results();
		write_reg(REG_CONNECT_TIMEOUT, ct[TimeW-1:0]);
		write_reg(REG_REPLY_TIMEOUT, rt[TimeW-1:0]);
		write_reg(REG_CLOSE_HOLD, ch[TimeW-1:0]);
		write_reg(REG_RETRY_LIMIT, {junk[TimeW-1:RetryW], rl[RetryW-1:0]});
		write_reg(REG_HOST_PRESENT, {junk[TimeW-1:1], host});
		if (unmapped)
			write_reg(REG_UNMAPPED, junk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		request = 1'b0;
		link_up = 1'b0;
		reply_status = REPLY_NONE;
		tick = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_CONNECT_TIMEOUT;
		cfg_data = '0;
		gap_pct = 0;
		stall_pct = 0;
		hold_requests = 0;
		holds_seen = 0;
		hold_left = 0;
		idle_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Connect retry, link up during the connect wait, unused reply code, retries spent into close.
		apply_settings(1, 1, 0, 2, 1'b1, 1'b0);
		send_poll(1'b0, 1'b0, REPLY_NONE, 1'b0);
		send_poll(1'b1, 1'b0, REPLY_NONE, 1'b0);
		send_poll(1'b1, 1'b0, REPLY_NONE, 1'b0);
		send_poll(1'b0, 1'b0, REPLY_NONE, 1'b1);
		send_poll(1'b0, 1'b0, REPLY_NONE, 1'b1);
		send_poll(1'b0, 1'b0, REPLY_NONE, 1'b1);
		send_poll(1'b0, 1'b0, REPLY_NONE, 1'b0);
		send_poll(1'b0, 1'b1, REPLY_NONE, 1'b1);
		send_poll(1'b0, 1'b0, REPLY_UNUSED, 1'b1);
		send_poll(1'b0, 1'b0, REPLY_UNUSED, 1'b1);
		send_poll(1'b0, 1'b0, REPLY_NONE, 1'b1);
		send_poll(1'b0, 1'b0, REPLY_NONE, 1'b0);
		send_poll(1'b0, 1'b0, REPLY_NONE, 1'b1);

		// A zero retry limit aborts on the first connect timeout; a reject beats a timeout.
		apply_settings(0, 0, 0, 0, 1'b1, 1'b0);
		send_poll(1'b1, 1'b0, REPLY_NONE, 1'b1);
		send_poll(1'b0, 1'b0, REPLY_NONE, 1'b1);
		send_poll(1'b0, 1'b0, REPLY_NONE, 1'b1);
		send_poll(1'b0, 1'b0, REPLY_NONE, 1'b1);
		send_poll(1'b1, 1'b1, REPLY_NONE, 1'b0);
		send_poll(1'b0, 1'b1, REPLY_NONE, 1'b0);
		send_poll(1'b0, 1'b0, REPLY_NONE, 1'b0);
		send_poll(1'b0, 1'b0, REPLY_REJECT, 1'b1);

		// With no host, connect falls back to idle.
		apply_settings(0, 0, 0, 0, 1'b0, 1'b0);
		send_poll(1'b0, 1'b0, REPLY_NONE, 1'b0);
		send_poll(1'b1, 1'b0, REPLY_NONE, 1'b0);
		send_poll(1'b0, 1'b0, REPLY_NONE, 1'b0);
		send_poll(1'b1, 1'b1, REPLY_NONE, 1'b0);
		send_poll(1'b0, 1'b1, REPLY_NONE, 1'b0);
		send_poll(1'b0, 1'b1, REPLY_NONE, 1'b0);

		// A full-scale hold does not expire; a shorter hold time then releases it.
		apply_settings(3, 3, 65535, 4, 1'b1, 1'b0);
		send_poll(1'b1, 1'b1, REPLY_NONE, 1'b0);
		send_poll(1'b0, 1'b1, REPLY_NONE, 1'b0);
		send_poll(1'b0, 1'b0, REPLY_NONE, 1'b0);
		send_poll(1'b0, 1'b0, REPLY_GOOD, 1'b0);
		send_poll(1'b0, 1'b0, REPLY_NONE, 1'b0);
		repeat (40)
			send_poll(1'b0, 1'b0, REPLY_NONE, 1'b1);
		apply_settings(3, 3, 2, 4, 1'b1, 1'b0);
		send_poll(1'b0, 1'b0, REPLY_NONE, 1'b1);

		// Random transactions; each one draws its own link, reply and tick rates.
		link_pct = 50;
		reply_pct = 30;
		tick_pct = 70;
		for (pass_no = 0; pass_no < 8; pass_no++) begin
			case (pass_no)
				0: apply_settings(0, 0, 0, 1, 1'b1, 1'b0);
				1: apply_settings(65535, 65535, 3, 15, 1'b1, 1'b0);
				default: apply_settings($urandom_range(0, 6), $urandom_range(0, 6),
					$urandom_range(0, 4), $urandom_range(1, 15),
					$urandom_range(9) != 0, pass_no == 3);
			endcase
			case (pass_no % 4)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 65;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 65;
				end
				default: begin
					gap_pct = 29;
					stall_pct = 29;
				end
			endcase
			for (n = 0; n < PHASE_POLLS; n++) begin
				if (sb.phase_now == PHASE_IDLE) begin
					link_pct = ($urandom_range(3) == 0) ? 100 : $urandom_range(2, 50);
					reply_pct = $urandom_range(2, 50);
					tick_pct = $urandom_range(30, 100);
				end
				// Back-pressure until the input stalls, and once a full drain mid-stream.
				if (pass_no == 2 && n == 60)
					hold_requests++;
				if (pass_no == 5 && n == 95)
					wait_all_results();
				if ($urandom_range(99) < reply_pct)
					reply_pick = $urandom_range(1) ? REPLY_GOOD : REPLY_REJECT;
				else
					reply_pick = ($urandom_range(9) == 0) ? REPLY_UNUSED : REPLY_NONE;
				send_poll((sb.phase_now == PHASE_IDLE) ? ($urandom_range(99) < 60)
						: ($urandom_range(1) != 0),
					$urandom_range(99) < link_pct, reply_pick,
					$urandom_range(99) < tick_pct);
			end
		end

		wait_all_results();
		repeat (8) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
